// ===== rtl/core/z80se_pkg.sv =====
// Shared types and constants for the Z80 subset execute block.
package z80se_pkg;

	localparam int QUEUE_DEPTH = 2;

	// Opcodes and opcode groups
	localparam logic [7:0] OP_NOP = 8'h00;
	localparam logic [7:0] OP_DI  = 8'hF3;
	localparam logic [7:0] OP_EI  = 8'hFB;

	// Register file slots, Z80 register codes; slot 6 holds F
	localparam logic [2:0] REG_A  = 3'd7;
	localparam logic [2:0] REG_F  = 3'd6;
	localparam logic [2:0] REG_B  = 3'd0;
	localparam logic [2:0] REG_C  = 3'd1;
	localparam logic [2:0] REG_D  = 3'd2;
	localparam logic [2:0] REG_E  = 3'd3;
	localparam logic [2:0] REG_H  = 3'd4;
	localparam logic [2:0] REG_L  = 3'd5;
	localparam logic [2:0] SRC_HL = 3'd6;

	// Flag bit positions in F
	localparam int FLAG_S_BIT  = 7;
	localparam int FLAG_Z_BIT  = 6;
	localparam int FLAG_H_BIT  = 4;
	localparam int FLAG_PV_BIT = 2;
	localparam logic [7:0] FLAG_KEEP_MASK = 8'h28;

	// Cycle cost adders
	localparam logic [5:0] CYC_EXEC = 6'd4;
	localparam logic [5:0] CYC_MEM  = 6'd3;

	typedef enum logic [2:0] {
		K_NOP,
		K_LD,
		K_AND,
		K_XOR,
		K_OR,
		K_DI,
		K_EI,
		K_BAD
	} op_kind_t;

	// Decoded instruction word passed from front to back
	typedef struct packed {
		op_kind_t    kind;
		logic [2:0]  dst;
		logic [2:0]  src;
		logic        use_mem;
		logic [7:0]  mem_data;
		logic [5:0]  cycles;
	} uop_t;

endpackage

// ===== rtl/core/z80se_front.sv =====
// Front end: classifies the opcode and computes the cycle count.
module z80se_front (
	input  logic              [7:0] opcode,
	input  logic              [7:0] mem_data,
	input  logic              [3:0] fetch_cost,
	input  logic              [3:0] data_cost,
	output z80se_pkg::uop_t         uop
);
	import z80se_pkg::*;

	op_kind_t   kind;
	logic       use_mem;
	logic [5:0] cyc_base;

	always_comb begin
		unique case (opcode) inside
			[8'h40:8'h6F], [8'h78:8'h7F]: kind = K_LD;
			[8'hA0:8'hA7]:                kind = K_AND;
			[8'hA8:8'hAF]:                kind = K_XOR;
			[8'hB0:8'hB7]:                kind = K_OR;
			OP_DI:                        kind = K_DI;
			OP_EI:                        kind = K_EI;
			OP_NOP:                       kind = K_NOP;
			default:                      kind = K_BAD;
		endcase
	end

	// (HL) operand forms of LD and the logic ops
	assign use_mem = (opcode[2:0] == SRC_HL) &&
		(kind == K_LD || kind == K_AND || kind == K_XOR || kind == K_OR);

	assign cyc_base = {2'b00, fetch_cost};

	always_comb begin
		uop.kind     = kind;
		uop.dst      = opcode[5:3];
		uop.src      = opcode[2:0];
		uop.use_mem  = use_mem;
		uop.mem_data = mem_data;
		if (kind == K_BAD) begin
			uop.cycles = cyc_base;
		end else if (use_mem) begin
			uop.cycles = cyc_base + CYC_EXEC + CYC_MEM + {2'b00, data_cost};
		end else begin
			uop.cycles = cyc_base + CYC_EXEC;
		end
	end

endmodule

// ===== rtl/core/z80se_queue.sv =====
// Small register FIFO of decoded words between front and back.
module z80se_queue #(
	parameter int DEPTH = z80se_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  z80se_pkg::uop_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output z80se_pkg::uop_t pop_data
);
	import z80se_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	uop_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/z80se_back.sv =====
// Back end: register file, logic unit, PC and the result register.
module z80se_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  z80se_pkg::uop_t uop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic     [15:0] next_pc,
	output logic      [7:0] acc_out,
	output logic      [7:0] flags_out,
	output logic     [15:0] bc_out,
	output logic     [15:0] de_out,
	output logic     [15:0] hl_out,
	output logic            int_enabled,
	output logic      [5:0] cycles_taken,
	output logic            unimplemented
);
	import z80se_pkg::*;

	logic [7:0]  rf_q [8];
	logic [15:0] pc_q;
	logic        iff_q;
	logic        out_valid_q;

	logic [7:0]  rf_nxt [8];
	logic [15:0] pc_nxt;
	logic        iff_nxt;
	logic [7:0]  operand;
	logic [7:0]  logic_res;
	logic [7:0]  flags_new;
	logic        fire;

	assign in_ready  = !out_valid_q || out_ready;
	assign fire      = in_valid && in_ready;
	assign out_valid = out_valid_q;

	assign operand = uop.use_mem ? uop.mem_data : rf_q[uop.src];

	always_comb begin
		case (uop.kind)
			K_AND:   logic_res = rf_q[REG_A] & operand;
			K_XOR:   logic_res = rf_q[REG_A] ^ operand;
			default: logic_res = rf_q[REG_A] | operand;
		endcase
	end

	always_comb begin
		flags_new              = rf_q[REG_F] & FLAG_KEEP_MASK;
		flags_new[FLAG_S_BIT]  = logic_res[7];
		flags_new[FLAG_Z_BIT]  = (logic_res == 8'h00);
		flags_new[FLAG_H_BIT]  = (uop.kind == K_AND);
		flags_new[FLAG_PV_BIT] = ~^logic_res;
	end

	always_comb begin
		rf_nxt  = rf_q;
		iff_nxt = iff_q;
		pc_nxt  = (uop.kind == K_BAD) ? pc_q : pc_q + 16'd1;
		unique case (uop.kind)
			K_LD: begin
				rf_nxt[uop.dst] = operand;
			end
			K_AND, K_XOR, K_OR: begin
				rf_nxt[REG_A] = logic_res;
				rf_nxt[REG_F] = flags_new;
			end
			K_DI:   iff_nxt = 1'b0;
			K_EI:   iff_nxt = 1'b1;
			K_NOP, K_BAD: begin
			end
			default: begin
			end
		endcase
	end

	// Architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				rf_q[i] <= 8'h00;
			end
			pc_q        <= 16'h0000;
			iff_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				rf_q  <= rf_nxt;
				pc_q  <= pc_nxt;
				iff_q <= iff_nxt;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result word
	always_ff @(posedge clk) begin
		if (fire) begin
			next_pc       <= pc_nxt;
			acc_out       <= rf_nxt[REG_A];
			flags_out     <= rf_nxt[REG_F];
			bc_out        <= {rf_nxt[REG_B], rf_nxt[REG_C]};
			de_out        <= {rf_nxt[REG_D], rf_nxt[REG_E]};
			hl_out        <= {rf_nxt[REG_H], rf_nxt[REG_L]};
			int_enabled   <= iff_nxt;
			cycles_taken  <= uop.cycles;
			unimplemented <= (uop.kind == K_BAD);
		end
	end

endmodule

// ===== rtl/core/z80_subset_execute.sv =====
// Top level of the Z80 subset execute block: front decode, queue, back execute.
//
//   channel | signals                                       | direction
//   --------+-----------------------------------------------+----------
//   input   | in_valid/in_ready, opcode, mem_data,          | in
//           | fetch_cost, data_cost                         |
//   result  | out_valid/out_ready, next_pc, acc_out,        | out
//           | flags_out, bc_out, de_out, hl_out,            |
//           | int_enabled, cycles_taken, unimplemented      |
//
// One instruction per clock sustained while out_ready stays high. A word is
// decoded in the cycle it is accepted and lands in the queue; the back end
// pops it from the queue and executes it against the register file, and the
// result is held in the output register. The execute loop (register read,
// logic op, write back) sets the rate.
// arst_n clears the register file, PC, interrupt enable and all valid state.
// A stalled result holds the back end; the queue absorbs words until full,
// then in_ready drops.
module z80_subset_execute #(
	parameter int QUEUE_DEPTH = z80se_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic  [7:0] opcode,
	input  logic  [7:0] mem_data,
	input  logic  [3:0] fetch_cost,
	input  logic  [3:0] data_cost,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] next_pc,
	output logic  [7:0] acc_out,
	output logic  [7:0] flags_out,
	output logic [15:0] bc_out,
	output logic [15:0] de_out,
	output logic [15:0] hl_out,
	output logic        int_enabled,
	output logic  [5:0] cycles_taken,
	output logic        unimplemented
);
	import z80se_pkg::*;

	uop_t dec_uop;
	uop_t exe_uop;
	logic q_full;
	logic q_empty;
	logic exe_ready;
	logic q_push;
	logic q_pop;

	// Front: decode and cycle count, no state
	z80se_front u_front (
		.opcode     (opcode),
		.mem_data   (mem_data),
		.fetch_cost (fetch_cost),
		.data_cost  (data_cost),
		.uop        (dec_uop)
	);

	// Accept whenever the queue has room
	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;
	assign q_pop    = !q_empty && exe_ready;

	z80se_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (dec_uop),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.pop_data  (exe_uop)
	);

	// Back: executes in order, result held in an output register
	z80se_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (!q_empty),
		.in_ready      (exe_ready),
		.uop           (exe_uop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.next_pc       (next_pc),
		.acc_out       (acc_out),
		.flags_out     (flags_out),
		.bc_out        (bc_out),
		.de_out        (de_out),
		.hl_out        (hl_out),
		.int_enabled   (int_enabled),
		.cycles_taken  (cycles_taken),
		.unimplemented (unimplemented)
	);

endmodule

// ===== tb/sv/tb_z80_subset_execute.sv =====
// Self-checking testbench for the Z80 subset execute block: directed table plus random words.
`timescale 1ns / 1ps

module tb_z80_subset_execute;
	import z80se_pkg::*;

	// Opcode groups and a few unsupported opcodes used by the directed table
	localparam logic [7:0] OPC_LD_BASE  = 8'h40;
	localparam logic [7:0] OPC_AND_BASE = 8'hA0;
	localparam logic [7:0] OPC_XOR_BASE = 8'hA8;
	localparam logic [7:0] OPC_OR_BASE  = 8'hB0;
	localparam logic [7:0] OPC_GROUP_MASK = 8'hF8;
	localparam logic [7:0] OPC_HALT     = 8'h76;
	localparam logic [7:0] OPC_CP_B     = 8'hB8;
	localparam logic [7:0] OPC_RST_38   = 8'hFF;
	localparam logic [7:0] OPC_CCF      = 8'h3F;
	localparam logic [7:0] OPC_ADD_B    = 8'h80;

	// Flag masks in F
	localparam logic [7:0] F_S  = 8'(1 << FLAG_S_BIT);
	localparam logic [7:0] F_Z  = 8'(1 << FLAG_Z_BIT);
	localparam logic [7:0] F_H  = 8'(1 << FLAG_H_BIT);
	localparam logic [7:0] F_PV = 8'(1 << FLAG_PV_BIT);

	localparam int RESET_CYCLES    = 11;
	localparam int WORDS_PER_PHASE = 432;
	localparam int NUM_PHASES      = 4;
	localparam int HOLD_OFF_CYCLES = 60;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int DRAIN_CYCLES    = 8;
	localparam int MAX_REPORTS     = 10;
	localparam int NUM_ROWS        = 25;

	// One result word as the block presents it
	typedef struct packed {
		logic [15:0] pc;
		logic  [7:0] acc;
		logic  [7:0] flags;
		logic [15:0] bc;
		logic [15:0] de;
		logic [15:0] hl;
		logic        ie;
		logic  [5:0] cycles;
		logic        unimpl;
	} exec_result_t;

	// Directed row: input word, plus a hand-written result where one is given
	typedef struct packed {
		logic  [7:0]  op;
		logic  [7:0]  mem;
		logic  [3:0]  fc;
		logic  [3:0]  dc;
		logic         typed;
		exec_result_t result;
	} dir_row_t;

	function automatic logic [7:0] ld_op(input logic [2:0] dst, input logic [2:0] src);
		return OPC_LD_BASE | {2'b00, dst, src};
	endfunction

	function automatic logic [7:0] alu_op(input logic [7:0] base, input logic [2:0] src);
		return base | {5'b0, src};
	endfunction

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic  [7:0] opcode = '0;
	logic  [7:0] mem_data = '0;
	logic  [3:0] fetch_cost = '0;
	logic  [3:0] data_cost = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] next_pc;
	logic  [7:0] acc_out;
	logic  [7:0] flags_out;
	logic [15:0] bc_out;
	logic [15:0] de_out;
	logic [15:0] hl_out;
	logic        int_enabled;
	logic  [5:0] cycles_taken;
	logic        unimplemented;

	z80_subset_execute dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.mem_data(mem_data),
		.fetch_cost(fetch_cost),
		.data_cost(data_cost),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.next_pc(next_pc),
		.acc_out(acc_out),
		.flags_out(flags_out),
		.bc_out(bc_out),
		.de_out(de_out),
		.hl_out(hl_out),
		.int_enabled(int_enabled),
		.cycles_taken(cycles_taken),
		.unimplemented(unimplemented)
	);

	always #5 clk = ~clk;

	// Architectural state as the block should hold it
	logic  [7:0] gpr [8];
	logic [15:0] pc_model;
	logic        iff1_model;
	logic        iff2_model;

	exec_result_t pending_results[$];
	int          fail_count = 0;
	int          mismatch_count = 0;
	int          idle_cycles = 0;

	// Receiver pacing, set by the main sequence
	int          stall_pct = 0;
	logic        pressure_go = 1'b0;

	// Executes one instruction word against the model state and returns the
	// result word the block should send for it.
	function automatic exec_result_t execute_word(input logic [7:0] op, input logic [7:0] mem,
			input logic [3:0] fc, input logic [3:0] dc);
		exec_result_t r;
		logic [2:0] dst;
		logic [2:0] src;
		logic [7:0] operand;
		logic [7:0] res;
		logic [7:0] f;
		logic       ok;
		logic       hl_read;
		dst = op[5:3];
		src = op[2:0];
		operand = (src == SRC_HL) ? mem : gpr[src];
		ok = 1'b1;
		hl_read = 1'b0;
		if (op[7:6] == 2'b01 && dst != SRC_HL) begin
			// LD r,r' / LD r,(HL); dst 6 would be LD (HL),r, not supported
			gpr[dst] = operand;
			hl_read = (src == SRC_HL);
		end else if ((op & OPC_GROUP_MASK) == OPC_AND_BASE ||
				(op & OPC_GROUP_MASK) == OPC_XOR_BASE ||
				(op & OPC_GROUP_MASK) == OPC_OR_BASE) begin
			hl_read = (src == SRC_HL);
			if ((op & OPC_GROUP_MASK) == OPC_AND_BASE)
				res = gpr[REG_A] & operand;
			else if ((op & OPC_GROUP_MASK) == OPC_XOR_BASE)
				res = gpr[REG_A] ^ operand;
			else
				res = gpr[REG_A] | operand;
			// N and C always clear; bits 3 and 5 carried over
			f = gpr[REG_F] & FLAG_KEEP_MASK;
			if (res[7])
				f |= F_S;
			if (res == 8'h00)
				f |= F_Z;
			if ((op & OPC_GROUP_MASK) == OPC_AND_BASE)
				f |= F_H;
			if (~^res)
				f |= F_PV;
			gpr[REG_A] = res;
			gpr[REG_F] = f;
		end else if (op == OP_DI) begin
			iff1_model = 1'b0;
			iff2_model = 1'b0;
		end else if (op == OP_EI) begin
			iff1_model = 1'b1;
			iff2_model = 1'b1;
		end else if (op != OP_NOP) begin
			ok = 1'b0;
		end
		r.cycles = {2'b00, fc};
		if (ok) begin
			r.cycles += CYC_EXEC;
			pc_model = pc_model + 16'd1;
		end
		if (hl_read)
			r.cycles += CYC_MEM + {2'b00, dc};
		r.pc = pc_model;
		r.acc = gpr[REG_A];
		r.flags = gpr[REG_F];
		r.bc = {gpr[REG_B], gpr[REG_C]};
		r.de = {gpr[REG_D], gpr[REG_E]};
		r.hl = {gpr[REG_H], gpr[REG_L]};
		r.ie = iff1_model;
		r.unimpl = ~ok;
		return r;
	endfunction

	// Directed words. Rows marked typed carry the result written out by hand:
	// reset state, field extremes, unsupported opcodes, XOR A on zero flags.
	dir_row_t directed_rows [NUM_ROWS] = '{
		// NOP right after reset
		'{OP_NOP, 8'h00, 4'd0, 4'd0, 1'b1,
			'{16'd1, 8'h00, 8'h00, 16'h0, 16'h0, 16'h0, 1'b0, 6'd4, 1'b0}},
		// HALT is unsupported: PC holds, cost is the fetch alone
		'{OPC_HALT, 8'h00, 4'd15, 4'd15, 1'b1,
			'{16'd1, 8'h00, 8'h00, 16'h0, 16'h0, 16'h0, 1'b0, 6'd15, 1'b1}},
		// LD (HL),B is outside the subset
		'{ld_op(SRC_HL, REG_B), 8'hFF, 4'd0, 4'd0, 1'b1,
			'{16'd1, 8'h00, 8'h00, 16'h0, 16'h0, 16'h0, 1'b0, 6'd0, 1'b1}},
		// LD A,(HL) with both costs at max: the longest cycle count
		'{ld_op(REG_A, SRC_HL), 8'hFF, 4'd15, 4'd15, 1'b1,
			'{16'd2, 8'hFF, 8'h00, 16'h0, 16'h0, 16'h0, 1'b0, 6'd37, 1'b0}},
		'{OP_EI, 8'h00, 4'd9, 4'd15, 1'b1,
			'{16'd3, 8'hFF, 8'h00, 16'h0, 16'h0, 16'h0, 1'b1, 6'd13, 1'b0}},
		// XOR A clears A: Z and P/V set
		'{alu_op(OPC_XOR_BASE, REG_A), 8'h00, 4'd0, 4'd0, 1'b1,
			'{16'd4, 8'h00, F_Z | F_PV, 16'h0, 16'h0, 16'h0, 1'b1, 6'd4, 1'b0}},
		'{ld_op(REG_B, SRC_HL), 8'h80, 4'd0, 4'd0, 1'b0, '0},
		'{ld_op(REG_C, SRC_HL), 8'h01, 4'd3, 4'd7, 1'b0, '0},
		'{ld_op(REG_D, SRC_HL), 8'hFE, 4'd8, 4'd1, 1'b0, '0},
		'{ld_op(REG_E, SRC_HL), 8'h7F, 4'd5, 4'd10, 1'b0, '0},
		'{ld_op(REG_H, SRC_HL), 8'h55, 4'd2, 4'd4, 1'b0, '0},
		'{ld_op(REG_L, SRC_HL), 8'hAA, 4'd14, 4'd12, 1'b0, '0},
		'{ld_op(REG_A, REG_B), 8'h00, 4'd1, 4'd0, 1'b0, '0},
		'{alu_op(OPC_AND_BASE, SRC_HL), 8'h0F, 4'd0, 4'd6, 1'b0, '0},
		'{alu_op(OPC_OR_BASE, REG_C), 8'hFF, 4'd7, 4'd9, 1'b0, '0},
		'{alu_op(OPC_XOR_BASE, SRC_HL), 8'hFF, 4'd11, 4'd2, 1'b0, '0},
		'{alu_op(OPC_AND_BASE, REG_D), 8'h00, 4'd4, 4'd5, 1'b0, '0},
		'{alu_op(OPC_OR_BASE, SRC_HL), 8'h00, 4'd6, 4'd13, 1'b0, '0},
		'{ld_op(REG_E, REG_A), 8'h33, 4'd10, 4'd3, 1'b0, '0},
		'{OP_DI, 8'h00, 4'd12, 4'd8, 1'b0, '0},
		// NOP ignores the operand byte and its cost
		'{OP_NOP, 8'hFF, 4'd15, 4'd15, 1'b0, '0},
		'{OPC_CP_B, 8'h12, 4'd15, 4'd0, 1'b0, '0},
		'{OPC_RST_38, 8'hFF, 4'd3, 4'd15, 1'b0, '0},
		'{OPC_CCF, 8'h00, 4'd0, 4'd15, 1'b0, '0},
		'{OPC_ADD_B, 8'h80, 4'd8, 4'd8, 1'b0, '0}
	};

	// Offers one word, holding it until accepted. Idle gaps go in front of it.
	// Returns in the time step of the accepting edge.
	task automatic send_word(input logic [7:0] op, input logic [7:0] mem,
			input logic [3:0] fc, input logic [3:0] dc, input logic typed,
			input exec_result_t typed_result, input int idle_pct);
		exec_result_t predicted;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		mem_data <= mem;
		fetch_cost <= fc;
		data_cost <= dc;
		// Every offered word is taken in order, so predict now
		predicted = execute_word(op, mem, fc, dc);
		pending_results.push_back(typed ? typed_result : predicted);
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Random word: mostly legal loads and logic ops with random content,
	// some interrupt control and NOP, the rest any byte at all.
	task automatic send_random_word(input int idle_pct);
		logic [7:0] op;
		logic [2:0] dst;
		int         pick;
		pick = $urandom_range(99);
		if (pick < 35) begin
			dst = 3'($urandom_range(7));
			if (dst == SRC_HL)
				dst = REG_A;
			op = ld_op(dst, 3'($urandom_range(7)));
		end else if (pick < 70) begin
			case ($urandom_range(2))
				0: op = alu_op(OPC_AND_BASE, 3'($urandom_range(7)));
				1: op = alu_op(OPC_XOR_BASE, 3'($urandom_range(7)));
				default: op = alu_op(OPC_OR_BASE, 3'($urandom_range(7)));
			endcase
		end else if (pick < 80) begin
			case ($urandom_range(2))
				0: op = OP_NOP;
				1: op = OP_DI;
				default: op = OP_EI;
			endcase
		end else begin
			op = 8'($urandom_range(255));
		end
		send_word(op, 8'($urandom_range(255)), 4'($urandom_range(15)),
			4'($urandom_range(15)), 1'b0, '0, idle_pct);
	endtask

	// Receiver: one long hold-off when asked, random stalls otherwise
	int   hold_left = 0;
	logic hold_started = 1'b0;

	always @(posedge clk) begin
		if (pressure_go && !hold_started) begin
			hold_started <= 1'b1;
			hold_left <= HOLD_OFF_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Result checker: every accepted result against the oldest prediction
	exec_result_t want;
	exec_result_t got;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got = '{next_pc, acc_out, flags_out, bc_out, de_out, hl_out,
				int_enabled, cycles_taken, unimplemented};
			if (pending_results.size() == 0) begin
				fail_count++;
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result word: pc=%h a=%h f=%h", got.pc, got.acc,
						got.flags);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					fail_count++;
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("exp pc=%h a=%h f=%h bc=%h de=%h hl=%h ie=%b cyc=%0d bad=%b",
							want.pc, want.acc, want.flags, want.bc, want.de, want.hl,
							want.ie, want.cycles, want.unimpl);
						$display("got pc=%h a=%h f=%h bc=%h de=%h hl=%h ie=%b cyc=%0d bad=%b",
							got.pc, got.acc, got.flags, got.bc, got.de, got.hl,
							got.ie, got.cycles, got.unimpl);
					end
				end
			end
		end
	end

	// Watchdog: too long without any word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Sender idle and receiver stall percentages per phase:
	// none, sender idle, receiver stall, both lightly
	int idle_by_phase [NUM_PHASES] = '{0, 74, 0, 14};
	int stall_by_phase [NUM_PHASES] = '{0, 0, 74, 14};

	initial begin
		for (int i = 0; i < 8; i++)
			gpr[i] = 8'h00;
		pc_model = 16'h0000;
		iff1_model = 1'b0;
		iff2_model = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_word(directed_rows[i].op, directed_rows[i].mem, directed_rows[i].fc,
				directed_rows[i].dc, directed_rows[i].typed, directed_rows[i].result, 0);

		for (int p = 0; p < NUM_PHASES; p++) begin
			stall_pct <= stall_by_phase[p];
			// First phase opens with the receiver held off while words keep
			// coming, so the queue fills and in_ready drops
			if (p == 0)
				pressure_go <= 1'b1;
			for (int n = 0; n < WORDS_PER_PHASE; n++)
				send_random_word(idle_by_phase[p]);
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		// Room for any stray result behind the last one
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
